// File: hdl/binary_fsk_square_modulator_defines.svh
// assertion macros used by the modulator core
`ifndef BINARY_FSK_SQUARE_MODULATOR_DEFINES_SVH
`define BINARY_FSK_SQUARE_MODULATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, clocked on clk, off during reset
`define BFSK_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfsk assertion failed");
// next-cycle implication, clocked on clk, off during reset
`define BFSK_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfsk assertion failed");
`else
`define BFSK_ASSERT_IMP(lbl, ante, cons)
`define BFSK_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: hdl/bfsk_pkg.sv
// shared types and constants of the fsk square modulator
package bfsk_pkg;

    // field widths
    localparam int SPB_W   = 8;
    localparam int STEP_W  = 12;
    localparam int HALF_W  = 12;
    localparam int AMP_W   = 15;
    localparam int PHASE_W = 13;
    localparam int SMP_W   = 16;
    localparam int BYTE_W  = 8;
    localparam int BIT_W   = 3;
    localparam int ADDR_W  = 3;
    localparam int WDATA_W = 15;

    // register reset values: 2400/1200 Hz tones at 44100 Hz
    localparam logic [SPB_W-1:0]  SPB_RST       = 8'd74;
    localparam logic [STEP_W-1:0] STEP_ONE_RST  = 12'd16;
    localparam logic [STEP_W-1:0] STEP_ZERO_RST = 12'd8;
    localparam logic [HALF_W-1:0] HALF_RST      = 12'd147;
    localparam logic [AMP_W-1:0]  AMP_RST       = 15'd26213;

    // register indexes
    localparam logic [ADDR_W-1:0] REG_SAMPLES_PER_BIT = 3'd0;
    localparam logic [ADDR_W-1:0] REG_PHASE_STEP_ONE  = 3'd1;
    localparam logic [ADDR_W-1:0] REG_PHASE_STEP_ZERO = 3'd2;
    localparam logic [ADDR_W-1:0] REG_HALF_PERIOD     = 3'd3;
    localparam logic [ADDR_W-1:0] REG_AMPLITUDE       = 3'd4;

    // request commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [SPB_W-1:0]  samples_per_bit;
        logic [STEP_W-1:0] phase_step_one;
        logic [STEP_W-1:0] phase_step_zero;
        logic [HALF_W-1:0] half_period;
        logic [AMP_W-1:0]  amplitude;
    } cfg_t;

    // one result
    typedef struct packed {
        logic [SMP_W-1:0] sample;
        logic             sample_valid;
        logic             last_of_byte;
        logic             load_rejected;
    } res_t;

endpackage

// File: hdl/binary_fsk_square_modulator.sv
// top level of the binary fsk square-wave modulator
//
// Input stream s_axis: tuser is the command (0 load a byte, 1 sample tick),
// tdata is the byte for a load. Every request gives exactly one result.
// Output stream m_axis: tdata is the signed 16-bit sample, tlast marks the
// last sample of a byte, tuser[0] says the sample is real, tuser[1] flags a
// load that came while a byte was still playing.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr (0 samples
// per bit, 1 high tone step, 2 low tone step, 3 half period, 4 amplitude).
// Write only while the block is idle.
// An accepted request passes through the input register, then the state
// update and the result register, before its result appears on m_axis.
// Throughput is one request per cycle while m_axis is not stalled, as the
// phase accumulator and counter update in a single pass.
// Reset clears the state, empties both registers and loads the default
// tone settings. When the receiver stalls, the result register holds and
// s_axis takes one more request into the input register, then stalls too.
module binary_fsk_square_modulator
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [bfsk_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [bfsk_pkg::WDATA_W-1:0]  cfg_wdata,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] data_byte
    input  logic                          s_axis_tuser,   // [0] command
    // output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,   // [15:0] sample
    output logic                          m_axis_tlast,
    output logic [1:0]                    m_axis_tuser    // [0] sample_valid, [1] load_rejected
);

    bfsk_pkg::cfg_t cfg;
    bfsk_pkg::res_t core_res;
    bfsk_pkg::res_t out_res;

    logic                        in_valid_reg, in_valid_next;
    logic                        in_cmd_reg;
    logic [bfsk_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        s_accept;
    logic                        core_fire;
    logic                        out_valid;

    bfsk_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // handshake between the two registers
    assign core_fire     = in_valid_reg && (!out_valid || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || core_fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // input register
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (core_fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_cmd_reg  <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
    end

    bfsk_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .fire      (core_fire),
        .command   (in_cmd_reg),
        .data_byte (in_byte_reg),
        .res       (core_res)
    );

    bfsk_out_stage u_out
    (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (core_fire),
        .res   (core_res),
        .take  (m_axis_tready),
        .valid (out_valid),
        .res_q (out_res)
    );

    // output channel
    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = out_res.sample;
    assign m_axis_tlast  = out_res.last_of_byte;
    assign m_axis_tuser  = {out_res.load_rejected, out_res.sample_valid};

endmodule

// File: hdl/bfsk_cfg_regs.sv
// configuration register file of the fsk square modulator
module bfsk_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bfsk_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [bfsk_pkg::WDATA_W-1:0]  cfg_wdata,
    output bfsk_pkg::cfg_t                cfg
);

    bfsk_pkg::cfg_t cfg_reg;

    // register writes, no read-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.samples_per_bit <= bfsk_pkg::SPB_RST;
            cfg_reg.phase_step_one  <= bfsk_pkg::STEP_ONE_RST;
            cfg_reg.phase_step_zero <= bfsk_pkg::STEP_ZERO_RST;
            cfg_reg.half_period     <= bfsk_pkg::HALF_RST;
            cfg_reg.amplitude       <= bfsk_pkg::AMP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                bfsk_pkg::REG_SAMPLES_PER_BIT:
                    cfg_reg.samples_per_bit <= cfg_wdata[bfsk_pkg::SPB_W-1:0];
                bfsk_pkg::REG_PHASE_STEP_ONE:
                    cfg_reg.phase_step_one <= cfg_wdata[bfsk_pkg::STEP_W-1:0];
                bfsk_pkg::REG_PHASE_STEP_ZERO:
                    cfg_reg.phase_step_zero <= cfg_wdata[bfsk_pkg::STEP_W-1:0];
                bfsk_pkg::REG_HALF_PERIOD:
                    cfg_reg.half_period <= cfg_wdata[bfsk_pkg::HALF_W-1:0];
                bfsk_pkg::REG_AMPLITUDE:
                    cfg_reg.amplitude <= cfg_wdata[bfsk_pkg::AMP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/bfsk_core.sv
// modulator state and single-pass update for one request
`include "binary_fsk_square_modulator_defines.svh"

module bfsk_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  bfsk_pkg::cfg_t               cfg,
    input  logic                         fire,
    input  logic                         command,
    input  logic [bfsk_pkg::BYTE_W-1:0]  data_byte,
    output bfsk_pkg::res_t               res
);

    logic [bfsk_pkg::BYTE_W-1:0]  shift_byte_reg, shift_byte_next;
    logic                         busy_reg, busy_next;
    logic [bfsk_pkg::BIT_W-1:0]   bit_index_reg, bit_index_next;
    logic [bfsk_pkg::SPB_W-1:0]   sample_index_reg, sample_index_next;
    logic [bfsk_pkg::PHASE_W-1:0] phase_acc_reg, phase_acc_next;

    logic                         cur_bit;
    logic [bfsk_pkg::STEP_W-1:0]  step;
    logic [bfsk_pkg::PHASE_W-1:0] wrap;
    logic [bfsk_pkg::PHASE_W:0]   phase_sum;
    logic [bfsk_pkg::PHASE_W:0]   phase_wrapped;
    logic [bfsk_pkg::SPB_W:0]     sidx_inc;
    logic                         bit_done;
    logic [bfsk_pkg::SMP_W-1:0]   amp_ext;
    logic [bfsk_pkg::SMP_W-1:0]   tone_sample;

    // tone selection, msb first
    assign cur_bit = shift_byte_reg[3'd7 - bit_index_reg];
    assign step    = cur_bit ? cfg.phase_step_one : cfg.phase_step_zero;

    // square wave level from the current phase
    assign amp_ext     = {1'b0, cfg.amplitude};
    assign tone_sample = (phase_acc_reg < {1'b0, cfg.half_period}) ? amp_ext
                                                                    : (~amp_ext + 16'd1);

    // phase advance with a single wrap at twice the half period
    assign wrap          = {cfg.half_period, 1'b0};
    assign phase_sum     = {1'b0, phase_acc_reg} + {2'b00, step};
    assign phase_wrapped = (phase_sum >= {1'b0, wrap}) ? (phase_sum - {1'b0, wrap})
                                                       : phase_sum;

    // end of bit once the sample count reaches the register
    assign sidx_inc = {1'b0, sample_index_reg} + 9'd1;
    assign bit_done = (sidx_inc >= {1'b0, cfg.samples_per_bit});

    // next state and result
    always_comb
    begin
        shift_byte_next   = shift_byte_reg;
        busy_next         = busy_reg;
        bit_index_next    = bit_index_reg;
        sample_index_next = sample_index_reg;
        phase_acc_next    = phase_acc_reg;
        res               = '0;

        if (command == bfsk_pkg::CMD_LOAD)
        begin
            if (busy_reg)
            begin
                res.load_rejected = 1'b1;
            end
            else
            begin
                shift_byte_next   = data_byte;
                busy_next         = 1'b1;
                bit_index_next    = '0;
                sample_index_next = '0;
                phase_acc_next    = '0;
            end
        end
        else if (busy_reg)
        begin
            res.sample       = tone_sample;
            res.sample_valid = 1'b1;
            if (bit_done)
            begin
                sample_index_next = '0;
                phase_acc_next    = '0;
                if (bit_index_reg == 3'd7)
                begin
                    bit_index_next   = '0;
                    busy_next        = 1'b0;
                    res.last_of_byte = 1'b1;
                end
                else
                begin
                    bit_index_next = bit_index_reg + 3'd1;
                end
            end
            else
            begin
                sample_index_next = sidx_inc[bfsk_pkg::SPB_W-1:0];
                phase_acc_next    = phase_wrapped[bfsk_pkg::PHASE_W-1:0];
            end
        end
    end

    // state registers, updated once per request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_byte_reg   <= '0;
            busy_reg         <= 1'b0;
            bit_index_reg    <= '0;
            sample_index_reg <= '0;
            phase_acc_reg    <= '0;
        end
        else if (fire)
        begin
            shift_byte_reg   <= shift_byte_next;
            busy_reg         <= busy_next;
            bit_index_reg    <= bit_index_next;
            sample_index_reg <= sample_index_next;
            phase_acc_reg    <= phase_acc_next;
        end
    end

    // idle means all counters and phase are cleared
    `BFSK_ASSERT_IMP(a_idle_clear, !busy_reg,
        bit_index_reg == '0 && sample_index_reg == '0 && phase_acc_reg == '0)
    // accepted load starts a byte from the first sample
    `BFSK_ASSERT_NXT(a_load_start, fire && command == bfsk_pkg::CMD_LOAD && !busy_reg,
        busy_reg && bit_index_reg == '0 && sample_index_reg == '0)
    // last sample of a byte leaves the block idle
    `BFSK_ASSERT_NXT(a_last_idle, fire && res.last_of_byte, !busy_reg)
    // a rejected load keeps the byte in flight
    `BFSK_ASSERT_NXT(a_reject_keep, fire && res.load_rejected,
        busy_reg && $stable(shift_byte_reg) && $stable(bit_index_reg))

endmodule

// File: hdl/bfsk_out_stage.sv
// result register between the datapath and the output channel
module bfsk_out_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  bfsk_pkg::res_t res,
    input  logic           take,
    output logic           valid,
    output bfsk_pkg::res_t res_q
);

    logic           valid_reg, valid_next;
    bfsk_pkg::res_t res_reg;

    // occupancy of the result register
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign valid = valid_reg;
    assign res_q = res_reg;

endmodule

// File: tb/sv/binary_fsk_square_modulator_test.sv
`timescale 1ns / 1ps
// self-checking regression bench for the binary fsk square-wave modulator
module binary_fsk_square_modulator_test;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 950;
    localparam int IDLE_PCT     = 36;
    localparam int REPORT_MAX   = 10;
    localparam int DRAIN_CYCLES = 8;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic [bfsk_pkg::ADDR_W-1:0]  cfg_addr = '0;
    logic [bfsk_pkg::WDATA_W-1:0] cfg_wdata = '0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [7:0]                   s_axis_tdata = '0;     // [7:0] data_byte
    logic                         s_axis_tuser = 1'b0;   // [0] command
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [15:0]                  m_axis_tdata;          // [15:0] sample
    logic                         m_axis_tlast;
    logic [1:0]                   m_axis_tuser;          // [0] sample_valid, [1] load_rejected

    // mirror of the modulator registers and state
    bfsk_pkg::cfg_t                tone_cfg;
    logic [7:0]                    tx_byte;
    logic                          tx_busy;
    logic [2:0]                    tx_bit;
    logic [8:0]                    tx_count;
    logic [bfsk_pkg::PHASE_W-1:0]  tx_phase;

    bfsk_pkg::res_t expected_samples[$];
    int unsigned    mismatches = 0;
    int unsigned    cycles = 0;
    int unsigned    items_sent = 0;
    bit             steady = 1'b0;   // both sides run without idling

    binary_fsk_square_modulator u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("binary_fsk_square_modulator regression: fail");
            $finish;
        end
    end

    // next sample of the modulator for one request, advancing the mirror state
    function automatic bfsk_pkg::res_t modulate_request(logic cmd, logic [7:0] data);
        bfsk_pkg::res_t r;
        logic [15:0]    mag;
        int unsigned    step;
        int unsigned    wrap;
        int unsigned    acc;
        r = '0;
        if (cmd == bfsk_pkg::CMD_LOAD)
        begin
            // a load while playing is refused and leaves the state alone
            if (tx_busy)
                r.load_rejected = 1'b1;
            else
            begin
                tx_byte  = data;
                tx_busy  = 1'b1;
                tx_bit   = '0;
                tx_count = '0;
                tx_phase = '0;
            end
            return r;
        end
        if (!tx_busy)
            return r;
        // msb first; the bit picks the tone
        step = tx_byte[3'd7 - tx_bit] ? tone_cfg.phase_step_one : tone_cfg.phase_step_zero;
        mag = {1'b0, tone_cfg.amplitude};
        r.sample = (tx_phase < tone_cfg.half_period) ? mag : -mag;
        r.sample_valid = 1'b1;
        // accumulator wraps once at a full period
        wrap = tone_cfg.half_period * 2;
        acc = tx_phase + step;
        if (acc >= wrap)
            acc -= wrap;
        tx_phase = acc[bfsk_pkg::PHASE_W-1:0];
        // bit and byte boundaries restart the phase
        tx_count = tx_count + 1'b1;
        if (tx_count >= tone_cfg.samples_per_bit)
        begin
            tx_count = '0;
            tx_phase = '0;
            if (tx_bit == 3'd7)
            begin
                tx_bit = '0;
                tx_busy = 1'b0;
                r.last_of_byte = 1'b1;
            end
            else
                tx_bit = tx_bit + 1'b1;
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input bfsk_pkg::res_t want,
                                 input bfsk_pkg::res_t seen);
        mismatches++;
        if (mismatches <= REPORT_MAX)
        begin
            $display("mismatch (%s): expected sample %0d valid %0b last %0b rejected %0b",
                     what, $signed(want.sample), want.sample_valid, want.last_of_byte,
                     want.load_rejected);
            $display("    got sample %0d valid %0b last %0b rejected %0b",
                     $signed(seen.sample), seen.sample_valid, seen.last_of_byte,
                     seen.load_rejected);
        end
    endtask

    // result side: compare each accepted sample, stall at random
    always @(posedge clk)
    begin
        bfsk_pkg::res_t seen;
        bfsk_pkg::res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.sample = m_axis_tdata;
            seen.sample_valid = m_axis_tuser[0];
            seen.last_of_byte = m_axis_tlast;
            seen.load_rejected = m_axis_tuser[1];
            if (expected_samples.size() == 0)
                flag_mismatch("unexpected result", '0, seen);
            else
            begin
                want = expected_samples.pop_front();
                if (seen.sample !== want.sample ||
                    seen.sample_valid !== want.sample_valid ||
                    seen.last_of_byte !== want.last_of_byte ||
                    seen.load_rejected !== want.load_rejected)
                    flag_mismatch("field", want, seen);
            end
        end
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // one request on the input stream, predicted when accepted
    task automatic send_request(input logic cmd, input logic [7:0] data);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= data;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_samples.push_back(modulate_request(cmd, data));
        items_sent++;
        if (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
    endtask

    // load a byte and tick until it is done, with refused loads mixed in
    task automatic play_byte(input logic [7:0] data, input int reject_pct);
        send_request(bfsk_pkg::CMD_LOAD, data);
        while (tx_busy)
        begin
            if ($urandom_range(99) < reject_pct)
                send_request(bfsk_pkg::CMD_LOAD, 8'($urandom_range(0, 255)));
            else
                send_request(bfsk_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
        end
    endtask

    // hold the sender until every sample has come back
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bfsk_pkg::ADDR_W-1:0]  addr,
                             input logic [bfsk_pkg::WDATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    // full register set, written only once nothing is in flight
    task automatic write_settings(input int spb, input int step_one, input int step_zero,
                                  input int half, input int amp);
        wait_idle();
        write_reg(bfsk_pkg::REG_SAMPLES_PER_BIT, spb[bfsk_pkg::WDATA_W-1:0]);
        write_reg(bfsk_pkg::REG_PHASE_STEP_ONE, step_one[bfsk_pkg::WDATA_W-1:0]);
        write_reg(bfsk_pkg::REG_PHASE_STEP_ZERO, step_zero[bfsk_pkg::WDATA_W-1:0]);
        write_reg(bfsk_pkg::REG_HALF_PERIOD, half[bfsk_pkg::WDATA_W-1:0]);
        write_reg(bfsk_pkg::REG_AMPLITUDE, amp[bfsk_pkg::WDATA_W-1:0]);
        cfg_we <= 1'b0;
        tone_cfg.samples_per_bit = spb[bfsk_pkg::SPB_W-1:0];
        tone_cfg.phase_step_one  = step_one[bfsk_pkg::STEP_W-1:0];
        tone_cfg.phase_step_zero = step_zero[bfsk_pkg::STEP_W-1:0];
        tone_cfg.half_period     = half[bfsk_pkg::HALF_W-1:0];
        tone_cfg.amplitude       = amp[bfsk_pkg::AMP_W-1:0];
    endtask

    function automatic int pick_step(int max_step);
        case ($urandom_range(6))
            0: return 1;
            1: return max_step;
            default: return $urandom_range(1, max_step);
        endcase
    endfunction

    // random tone settings; steps stay below a full period
    task automatic pick_settings();
        int half;
        int max_step;
        int spb;
        int amp;
        case ($urandom_range(9))
            0: half = 1;
            1: half = 4095;
            2: half = $urandom_range(2, 4095);
            default: half = $urandom_range(2, 64);
        endcase
        max_step = (2 * half - 1 > 4095) ? 4095 : 2 * half - 1;
        spb = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 12);
        case ($urandom_range(9))
            0: amp = 0;
            1: amp = 32767;
            default: amp = $urandom_range(0, 32767);
        endcase
        write_settings(spb, pick_step(max_step), pick_step(max_step), half, amp);
    endtask

    // one byte at the reset tone settings
    task automatic test_default_tones();
        play_byte(8'($urandom_range(0, 255)), 0);
    endtask

    // idle ticks, refused load, all-ones and all-zeros bytes at extreme settings
    task automatic test_load_and_tick_basics();
        write_settings(1, 4095, 1, 4095, 32767);
        send_request(bfsk_pkg::CMD_TICK, 8'hFF);
        send_request(bfsk_pkg::CMD_LOAD, 8'hFF);
        send_request(bfsk_pkg::CMD_LOAD, 8'h00);
        while (tx_busy)
            send_request(bfsk_pkg::CMD_TICK, 8'h00);
        send_request(bfsk_pkg::CMD_TICK, 8'h00);
        play_byte(8'h00, 0);
        send_request(bfsk_pkg::CMD_TICK, 8'hFF);
    endtask

    // zero bit length acts as one sample per bit
    task automatic test_zero_samples_per_bit();
        write_settings(0, 3, 1, 2, 1);
        play_byte(8'h5A, 0);
    endtask

    // longest bit at the smallest period with no idling anywhere,
    // then the rest of the byte at the shortest bit length
    task automatic test_longest_bit();
        write_settings(255, 1, 1, 1, 32767);
        steady = 1'b1;
        send_request(bfsk_pkg::CMD_LOAD, 8'($urandom_range(0, 255)));
        while (tx_busy && tx_bit == 3'd0)
            send_request(bfsk_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
        write_settings(1, 1, 1, 1, 32767);
        while (tx_busy)
            send_request(bfsk_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
        wait_idle();
        steady = 1'b0;
    endtask

    // random settings, random bytes, idle ticks and refused loads
    task automatic test_random_traffic();
        int unsigned first;
        int          bytes_left;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS)
        begin
            pick_settings();
            bytes_left = $urandom_range(2, 10);
            while (bytes_left > 0 && items_sent - first < RANDOM_ITEMS)
            begin
                repeat ($urandom_range(0, 2))
                    send_request(bfsk_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
                play_byte(8'($urandom_range(0, 255)), 8);
                bytes_left--;
            end
        end
    endtask

    initial
    begin
        tone_cfg.samples_per_bit = bfsk_pkg::SPB_RST;
        tone_cfg.phase_step_one  = bfsk_pkg::STEP_ONE_RST;
        tone_cfg.phase_step_zero = bfsk_pkg::STEP_ZERO_RST;
        tone_cfg.half_period     = bfsk_pkg::HALF_RST;
        tone_cfg.amplitude       = bfsk_pkg::AMP_RST;
        tx_byte  = '0;
        tx_busy  = 1'b0;
        tx_bit   = '0;
        tx_count = '0;
        tx_phase = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_tones();
        test_load_and_tick_basics();
        test_zero_samples_per_bit();
        test_longest_bit();
        test_random_traffic();
        wait_idle();
        if (mismatches == 0 && expected_samples.size() == 0)
            $display("binary_fsk_square_modulator regression: pass");
        else
            $display("binary_fsk_square_modulator regression: fail");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/bfsk_pkg.sv
hdl/bfsk_cfg_regs.sv
hdl/bfsk_core.sv
hdl/bfsk_out_stage.sv
hdl/binary_fsk_square_modulator.sv
tb/sv/binary_fsk_square_modulator_test.sv
